/* rtl/mfst_pkg.sv */
`default_nettype none

package mfst_pkg;

  localparam int unsigned SLOTS_DEF = 6;
  localparam int unsigned ID_REGS   = 6;
  localparam int unsigned CFG_IW    = 3;

  localparam logic [CFG_IW-1:0] REG_TIMEOUT = 3'd6;
  localparam logic [15:0]       TIMEOUT_RST = 16'd100;

  localparam logic [4:0]  TYPE_FB_A = 5'h02;
  localparam logic [4:0]  TYPE_FB_B = 5'h18;
  localparam logic [15:0] AGE_NEVER = 16'hFFFF;
  localparam logic [14:0] TEMP_MAX  = 15'h7FFF;

  // Round-half-up offset and the divisor of the fixed point scaling.
  localparam logic [30:0] ROUND_OFS = 31'd32767;
  localparam logic [31:0] DIV_K     = 32'd65535;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DEC,
    ST_DRAIN,
    ST_POLL
  } state_e;

  typedef enum logic [1:0] {
    CH_POS,
    CH_VEL,
    CH_TQ
  } chan_e;

  typedef struct packed {
    logic  vld;
    chan_e ch;
  } scale_req_t;

  function automatic logic [14:0] chan_span(chan_e ch);
    logic [14:0] s;
    case (ch)
      CH_POS:  s = 15'd25140;
      CH_VEL:  s = 15'd8800;
      CH_TQ:   s = 15'd3400;
      default: s = 15'd0;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] id_reset(int unsigned i);
    logic [7:0] v;
    case (i)
      0:       v = 8'd17;
      1:       v = 8'd18;
      2:       v = 8'd19;
      3:       v = 8'd33;
      4:       v = 8'd34;
      5:       v = 8'd35;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* rtl/mfst_scale.sv */
`default_nettype none

module mfst_scale (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire mfst_pkg::scale_req_t req_i,
  input  wire logic [15:0]        raw_i,
  output mfst_pkg::scale_req_t    rsp_o,
  output logic [15:0]             val_o
);
  import mfst_pkg::*;

  // Stage 1: raw * span, registered.
  logic [30:0] prod_q, prod_d;
  scale_req_t  tag_q;

  assign prod_d = 31'(raw_i) * 31'(chan_span(req_i.ch));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '{vld: 1'b0, ch: CH_POS};
    end else begin
      tag_q <= req_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // Stage 2: floor((prod + 32767) / 65535) by reciprocal estimate, one correction, minus half the span.
  logic [30:0] m;
  logic [31:0] est_sum;
  logic [15:0] q_est;
  logic [31:0] rem;
  logic [15:0] q;

  always_comb begin
    m       = prod_q + ROUND_OFS;
    est_sum = {1'b0, m} + 32'(m[30:16]);
    q_est   = est_sum[31:16];
    rem     = {1'b0, m} - {q_est, 16'h0000} + 32'(q_est);
    q       = q_est + 16'(rem >= DIV_K);
    val_o   = q - 16'(chan_span(tag_q.ch) >> 1);
  end

  assign rsp_o = tag_q;

endmodule

`default_nettype wire

/* rtl/motor_feedback_status_table.sv */
// Motor feedback status table. Feedback frames (cmd 0) that carry an extended
// id, a type of 2 or 24 and a motor id configured for a slot update the lowest
// matching slot: fault and mode bits, saturated temperature, the time of the
// transfer, and online. Position, velocity and torque are scaled by one shared
// multiplier with a reciprocal divide stage, used three times in a row, so a
// matching frame holds the input through an accept, three issues and one drain;
// a frame that does not match is dropped at acceptance and leaves the input
// ready. A poll (cmd 1) is accepted and then emits MOTOR_SLOTS snapshot results,
// one per cycle while the output side takes them; each slot's timeout check is
// done in the cycle its result is loaded. The input is not ready until the last
// result is loaded into the output register. Configuration writes are taken any
// cycle but must only occur while the block is idle. Slots at index 6 and up have
// no id register and serve motor id 0.
`default_nettype none

module motor_feedback_status_table #(
  parameter int unsigned MOTOR_SLOTS = mfst_pkg::SLOTS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // configuration
  input  wire logic                        cfg_we_i,
  input  wire logic [mfst_pkg::CFG_IW-1:0] cfg_idx_i,
  input  wire logic [15:0]                 cfg_wdata_i,
  // input channel
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic                        cmd_i,
  input  wire logic [28:0]                 frame_id_i,
  input  wire logic [63:0]                 frame_data_i,
  input  wire logic                        is_extended_i,
  input  wire logic [31:0]                 now_ms_i,
  // result channel
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [2:0]                       slot_o,
  output logic [7:0]                       drive_id_o,
  output logic                             online_o,
  output logic [5:0]                       fault_bits_o,
  output logic [1:0]                       mode_state_o,
  output logic signed [14:0]               pos_mrad_o,
  output logic signed [13:0]               vel_crad_o,
  output logic signed [11:0]               tq_cnm_o,
  output logic [14:0]                      temp_dc_o,
  output logic [15:0]                      age_ms_o,
  output logic [15:0]                      snap_seq_o,
  output logic                             last_o
);
  import mfst_pkg::*;

  localparam int unsigned SIW = (MOTOR_SLOTS > 1) ? $clog2(MOTOR_SLOTS) : 1;
  localparam logic [SIW-1:0] LAST_SLOT = SIW'(MOTOR_SLOTS - 1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [7:0]  mid [MOTOR_SLOTS];
  logic [15:0] timeout_q;

  for (genvar g = 0; g < MOTOR_SLOTS; g++) begin : g_id
    if (g < ID_REGS) begin : g_reg
      logic [7:0] id_q;
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          id_q <= id_reset(g);
        end else if (cfg_we_i && cfg_idx_i == CFG_IW'(g)) begin
          id_q <= cfg_wdata_i[7:0];
        end
      end
      assign mid[g] = id_q;
    end else begin : g_fixed
      assign mid[g] = 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RST;
    end else if (cfg_we_i && cfg_idx_i == REG_TIMEOUT) begin
      timeout_q <= cfg_wdata_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Status table
  // ---------------------------------------------------------------------------
  logic        online_q [MOTOR_SLOTS];
  logic [5:0]  fault_q  [MOTOR_SLOTS];
  logic [1:0]  mode_q   [MOTOR_SLOTS];
  logic [14:0] pos_q    [MOTOR_SLOTS];
  logic [13:0] vel_q    [MOTOR_SLOTS];
  logic [11:0] tq_q     [MOTOR_SLOTS];
  logic [14:0] temp_q   [MOTOR_SLOTS];
  logic [31:0] seen_q   [MOTOR_SLOTS];
  logic [15:0] snap_q;

  // ---------------------------------------------------------------------------
  // Frame filter: lowest slot whose id matches wins
  // ---------------------------------------------------------------------------
  logic           hit;
  logic [SIW-1:0] hit_idx;
  logic           type_ok;
  logic           take_frame;
  logic           in_fire;

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = MOTOR_SLOTS - 1; i >= 0; i--) begin
      if (mid[i] == frame_id_i[15:8]) begin
        hit     = 1'b1;
        hit_idx = SIW'(i);
      end
    end
    type_ok = frame_id_i[28:24] inside {TYPE_FB_A, TYPE_FB_B};
  end

  assign in_fire    = in_valid_i && in_ready_o;
  assign take_frame = in_fire && !cmd_i && is_extended_i && type_ok && hit;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  state_e         st_q, st_d;
  chan_e          ch_q, ch_d;
  logic [SIW-1:0] idx_q, idx_d;
  logic [SIW-1:0] slot_q;
  logic [47:0]    data_q;
  logic [31:0]    now_q;
  logic           out_valid_q;
  logic           load_out;
  scale_req_t     req;
  scale_req_t     rsp;
  logic [15:0]    raw;
  logic [15:0]    sval;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      ch_q  <= CH_POS;
      idx_q <= '0;
    end else begin
      st_q  <= st_d;
      ch_q  <= ch_d;
      idx_q <= idx_d;
    end
  end

  always_comb begin
    st_d       = st_q;
    ch_d       = ch_q;
    idx_d      = idx_q;
    in_ready_o = 1'b0;
    load_out   = 1'b0;
    req        = '{vld: 1'b0, ch: ch_q};
    case (st_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (cmd_i) begin
            st_d  = ST_POLL;
            idx_d = '0;
          end else if (take_frame) begin
            st_d = ST_DEC;
            ch_d = CH_POS;
          end
        end
      end
      ST_DEC: begin
        // issue one channel per cycle to the shared scaler
        req.vld = 1'b1;
        case (ch_q)
          CH_POS:  ch_d = CH_VEL;
          CH_VEL:  ch_d = CH_TQ;
          default: st_d = ST_DRAIN;
        endcase
      end
      ST_DRAIN: begin
        st_d = ST_IDLE;
      end
      ST_POLL: begin
        // advance when the output register is free or being drained
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          idx_d    = idx_q + SIW'(1);
          if (idx_q == LAST_SLOT) begin
            st_d = ST_IDLE;
          end
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    case (ch_q)
      CH_POS:  raw = data_q[47:32];
      CH_VEL:  raw = data_q[31:16];
      CH_TQ:   raw = data_q[15:0];
      default: raw = 16'h0000;
    endcase
  end

  mfst_scale u_scale (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .raw_i  (raw),
    .rsp_o  (rsp),
    .val_o  (sval)
  );

  // Hold the frame payload and poll time for the sequencer.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      data_q <= frame_data_i[63:16];
      now_q  <= now_ms_i;
      slot_q <= hit_idx;
    end
  end

  // ---------------------------------------------------------------------------
  // Timeout check and age of the slot being snapshotted
  // ---------------------------------------------------------------------------
  logic [31:0] age_full;
  logic        online_new;
  logic [15:0] age_sat;

  always_comb begin
    age_full   = now_q - seen_q[idx_q];
    online_new = online_q[idx_q] && !(age_full > 32'(timeout_q));
    if (seen_q[idx_q] == 32'd0 || age_full[31:16] != 16'h0000) begin
      age_sat = AGE_NEVER;
    end else begin
      age_sat = age_full[15:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Table update
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MOTOR_SLOTS; i++) begin
        online_q[i] <= 1'b0;
        fault_q[i]  <= '0;
        mode_q[i]   <= '0;
        pos_q[i]    <= '0;
        vel_q[i]    <= '0;
        tq_q[i]     <= '0;
        temp_q[i]   <= '0;
        seen_q[i]   <= '0;
      end
      snap_q <= '0;
    end else begin
      if (take_frame) begin
        fault_q[hit_idx]  <= frame_id_i[21:16];
        mode_q[hit_idx]   <= frame_id_i[23:22];
        temp_q[hit_idx]   <= frame_data_i[15] ? TEMP_MAX : frame_data_i[14:0];
        online_q[hit_idx] <= 1'b1;
        seen_q[hit_idx]   <= now_ms_i;
      end
      if (in_fire && cmd_i) begin
        snap_q <= snap_q + 16'd1;
      end
      if (rsp.vld) begin
        case (rsp.ch)
          CH_POS:  pos_q[slot_q] <= sval[14:0];
          CH_VEL:  vel_q[slot_q] <= sval[13:0];
          CH_TQ:   tq_q[slot_q]  <= sval[11:0];
          default: ;
        endcase
      end
      if (load_out) begin
        online_q[idx_q] <= online_new;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      slot_o       <= 3'(idx_q);
      drive_id_o   <= mid[idx_q];
      online_o     <= online_new;
      fault_bits_o <= fault_q[idx_q];
      mode_state_o <= mode_q[idx_q];
      pos_mrad_o   <= pos_q[idx_q];
      vel_crad_o   <= vel_q[idx_q];
      tq_cnm_o     <= tq_q[idx_q];
      temp_dc_o    <= temp_q[idx_q];
      age_ms_o     <= age_sat;
      snap_seq_o   <= snap_q;
      last_o       <= (idx_q == LAST_SLOT);
    end
  end

  assign out_valid_o = out_valid_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_rsp_in_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.vld |-> (st_q == ST_DEC || st_q == ST_DRAIN))
    else $error("scaler response outside frame decode");

  a_snap_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && cmd_i) |=> snap_q == $past(snap_q) + 16'd1)
    else $error("snapshot counter did not advance on poll");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(slot_o) < MOTOR_SLOTS)
    else $error("snapshot slot out of range");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> !rsp.vld && !req.vld)
    else $error("snapshot load overlaps frame decode");

endmodule

`default_nettype wire
